[sv/mstt_pkg.sv]
package mstt_pkg;

	localparam int NUM_SLOTS   = 8;
	localparam int MAX_RESULTS = 8;
	localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	// function codes
	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;
	localparam logic [1:0] OP_EXEC   = 2'd3;

	// result status codes
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_DUE  = 2'd2;
	localparam logic [1:0] ST_NONE = 2'd3;

	typedef struct packed {
		logic load;    // capture a new transaction, rewind the scan
		logic work;    // process the slot under the scan pointer
		logic adv;     // advance the scan pointer
	} mstt_cmd_t;

	typedef struct packed {
		logic finish;  // result for this visit is ready to emit
		logic last;    // held result closes the transaction
	} mstt_sts_t;

endpackage

[sv/mstt_in_if.sv]
interface mstt_in_if;
	import mstt_pkg::*;

	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] start_delay;
	logic [15:0] reload_period;
	logic [2:0]  slot_index;

	modport source (output valid, func, start_delay, reload_period, slot_index, input ready);
	modport sink   (input valid, func, start_delay, reload_period, slot_index, output ready);

endinterface

[sv/mstt_out_if.sv]
interface mstt_out_if;
	import mstt_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [2:0] slot_id;
	logic       last;

	modport source (output valid, status, slot_id, last, input ready);
	modport sink   (input valid, status, slot_id, last, output ready);

endinterface

[sv/mstt_ctrl.sv]
module mstt_ctrl
	import mstt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  mstt_sts_t sts,
	output mstt_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_EMIT);

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.work = 1'b0;
		cmd.adv  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.work = 1'b1;
				if (sts.finish) begin
					state_d = S_EMIT;
				end else begin
					cmd.adv = 1'b1;
				end
			end
			S_EMIT: begin
				if (rsp_ready) begin
					if (sts.last) begin
						state_d = S_IDLE;
					end else begin
						// resume the execute scan past the slot just reported
						cmd.adv = 1'b1;
						state_d = S_SCAN;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[sv/mstt_dp.sv]
module mstt_dp
	import mstt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  mstt_cmd_t   cmd,
	output mstt_sts_t   sts,
	input  logic [1:0]  func,
	input  logic [15:0] start_delay,
	input  logic [15:0] reload_period,
	input  logic [2:0]  slot_index,
	output logic [1:0]  status,
	output logic [2:0]  slot_id,
	output logic        last
);

	// slot table
	logic                 active_q [NUM_SLOTS];
	logic [15:0]          cd_q     [NUM_SLOTS];
	logic [15:0]          rl_q     [NUM_SLOTS];
	logic [7:0]           pend_q   [NUM_SLOTS];

	// transaction registers
	logic [1:0]           op_q;
	logic [15:0]          delay_q;
	logic [15:0]          period_q;
	logic [2:0]           idx_q;
	logic [NUM_SLOTS-1:0] mask_q;
	logic [SLOT_W-1:0]    ptr_q;
	logic [CNT_W-1:0]     cnt_q;

	// result register
	logic [1:0]           status_q;
	logic [2:0]           id_q;
	logic                 last_q;

	logic                 at_end;
	logic                 hit;
	logic                 higher;
	logic                 finish;
	logic                 del_ok;
	logic [SLOT_W-1:0]    del_ptr;
	logic [1:0]           res_status;
	logic [2:0]           res_id;
	logic                 res_last;

	assign at_end  = (ptr_q == SLOT_W'(NUM_SLOTS - 1));
	assign del_ok  = (32'(idx_q) < NUM_SLOTS);
	assign del_ptr = SLOT_W'(idx_q);

	always_comb begin
		higher = 1'b0;
		for (int j = 0; j < NUM_SLOTS; j++) begin
			if (SLOT_W'(j) > ptr_q) begin
				higher = higher | mask_q[j];
			end
		end
	end

	always_comb begin
		hit        = 1'b0;
		finish     = 1'b0;
		res_status = ST_DONE;
		res_id     = 3'd0;
		res_last   = 1'b1;
		unique case (op_q)
			OP_CREATE: begin
				hit    = !active_q[ptr_q];
				finish = hit || at_end;
				if (hit) begin
					res_id = 3'(ptr_q);
				end else begin
					res_status = ST_FULL;
				end
			end
			OP_DELETE: begin
				finish = 1'b1;
			end
			OP_TICK: begin
				finish = at_end;
			end
			OP_EXEC: begin
				hit    = mask_q[ptr_q];
				finish = hit || at_end;
				if (hit) begin
					res_status = ST_DUE;
					res_id     = 3'(ptr_q);
					res_last   = !higher || (cnt_q == CNT_W'(MAX_RESULTS - 1));
				end else begin
					res_status = ST_NONE;
				end
			end
			default: begin
				finish = 1'b1;
			end
		endcase
	end

	assign sts.finish = finish;
	assign sts.last   = last_q;
	assign status     = status_q;
	assign slot_id    = id_q;
	assign last       = last_q;

	// payload capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= func;
			delay_q  <= start_delay;
			period_q <= reload_period;
			idx_q    <= slot_index;
		end
		if (cmd.work) begin
			status_q <= res_status;
			id_q     <= res_id;
			last_q   <= res_last;
		end
	end

	// scan control and slot table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			cnt_q  <= '0;
			mask_q <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				active_q[i] <= 1'b0;
				cd_q[i]     <= 16'd0;
				rl_q[i]     <= 16'd0;
				pend_q[i]   <= 8'd0;
			end
		end else begin
			if (cmd.load) begin
				ptr_q <= '0;
				cnt_q <= '0;
				for (int i = 0; i < NUM_SLOTS; i++) begin
					mask_q[i] <= (pend_q[i] != 8'd0);
				end
			end else if (cmd.adv) begin
				ptr_q <= ptr_q + SLOT_W'(1);
			end
			if (cmd.work) begin
				unique case (op_q)
					OP_CREATE: begin
						if (hit) begin
							active_q[ptr_q] <= 1'b1;
							cd_q[ptr_q]     <= delay_q;
							rl_q[ptr_q]     <= period_q;
							pend_q[ptr_q]   <= 8'd0;
						end
					end
					OP_DELETE: begin
						if (del_ok) begin
							active_q[del_ptr] <= 1'b0;
							cd_q[del_ptr]     <= 16'd0;
							rl_q[del_ptr]     <= 16'd0;
							pend_q[del_ptr]   <= 8'd0;
						end
					end
					OP_TICK: begin
						if (active_q[ptr_q]) begin
							if (cd_q[ptr_q] == 16'd0) begin
								if (pend_q[ptr_q] != 8'hFF) begin
									pend_q[ptr_q] <= pend_q[ptr_q] + 8'd1;
								end
								if (rl_q[ptr_q] != 16'd0) begin
									cd_q[ptr_q] <= rl_q[ptr_q];
								end
							end else begin
								cd_q[ptr_q] <= cd_q[ptr_q] - 16'd1;
							end
						end
					end
					OP_EXEC: begin
						if (hit) begin
							cnt_q <= cnt_q + CNT_W'(1);
							if (rl_q[ptr_q] == 16'd0) begin
								// one-shot: drop the slot with any remaining runs
								active_q[ptr_q] <= 1'b0;
								cd_q[ptr_q]     <= 16'd0;
								rl_q[ptr_q]     <= 16'd0;
								pend_q[ptr_q]   <= 8'd0;
							end else begin
								pend_q[ptr_q] <= pend_q[ptr_q] - 8'd1;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

[sv/multi_slot_task_timer.sv]
// Slot table of a time-triggered cooperative scheduler.
// Channels: req (sink) carries one command transaction: func selects create,
// delete, tick or execute; start_delay and reload_period feed create,
// slot_index feeds delete. rsp (source) returns result transactions with
// status, slot_id and last; last marks the final result of a command.
// Create, delete and tick return one result; execute returns one result per
// slot with pending runs (lowest slot first, at most eight) or a single
// "nothing due" result.
// Timing: the controller walks the slots one per cycle through the datapath,
// pausing while a result waits to be taken. Delete finishes on its first
// visit, tick visits every slot, create stops at the first free slot (or at
// the last slot when none is free), execute stops at each due slot and
// resumes after its result is taken, ending at the last due slot, or at the
// last slot when nothing is due. A command is accepted while idle; a new
// command is taken the cycle after the last result is gone.
// Reset clears every slot (inactive, zero countdown, reload and pending) and
// returns the controller to idle. A stalled receiver holds the result
// register and freezes the scan; nothing is dropped or repeated.
module multi_slot_task_timer
	import mstt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	mstt_in_if.sink    req,
	mstt_out_if.source rsp
);

	mstt_cmd_t cmd;
	mstt_sts_t sts;

	// sequence the scan: accept, visit slots, hold each result until taken
	mstt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// slot table, scan pointer and result register
	mstt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (req.func),
		.start_delay   (req.start_delay),
		.reload_period (req.reload_period),
		.slot_index    (req.slot_index),
		.status        (rsp.status),
		.slot_id       (rsp.slot_id),
		.last          (rsp.last)
	);

endmodule
